>>> sv/hbpf_pkg.sv
// Shared constants and types for the H-bridge polarity-flip PWM block.
package hbpf_pkg;

   // Field and register widths.
   localparam int COUNT_W  = 16;
   localparam int PCT_W    = 7;
   localparam int DUTY_W   = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // Divider geometry: numerator bits, divisor bits and quotient bits kept.
   localparam int NUM_W    = 24;
   localparam int DEN_W    = 16;
   localparam int QUOT_W   = 9;
   localparam int DIV_STEPS = NUM_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Arithmetic width for the duty shaping.
   localparam int SHAPE_W  = 10;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTH_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POWER_PCT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLIP_PERIOD = 2'd2;

   // Reset values of the registers.
   localparam logic [PCT_W-1:0]   PCT_RESET    = 7'd100;
   localparam logic [COUNT_W-1:0] PERIOD_RESET = 16'd1000;

   // Limits and duty constants.
   localparam logic [PCT_W-1:0]   PCT_FULL    = 7'd100;
   localparam logic [COUNT_W-1:0] PERIOD_MIN  = 16'd2;
   localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;
   localparam logic [SHAPE_W-1:0] DUTY_MAX    = 10'd255;
   localparam logic [SHAPE_W-1:0] DUTY_MID    = 10'd128;
   localparam logic [SHAPE_W-1:0] DUTY_FALL   = 10'd383;

   // Selects how the divider quotient is turned into the two duties.
   typedef struct packed {
      logic smooth;    // ramped waveform instead of hard switching
      logic polarity;  // polarity after this step
      logic high_half; // counter above half the period
   } shape_ctrl_type;

endpackage

>>> sv/hbpf_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module hbpf_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [hbpf_pkg::NUM_W-1:0]    numer,
   input  logic [hbpf_pkg::DEN_W-1:0]    denom,
   output logic                          done,
   output logic [hbpf_pkg::QUOT_W-1:0]   quot
);

   logic [hbpf_pkg::NUM_W-1:0]     num_ff, num_in;
   logic [hbpf_pkg::DEN_W-1:0]     den_ff, den_in;
   logic [hbpf_pkg::DEN_W-1:0]     rem_ff, rem_in;
   logic [hbpf_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [hbpf_pkg::DEN_W:0]       trial;
   logic [hbpf_pkg::DEN_W:0]       diff;
   logic                           fits;

   // One step: bring down the next numerator bit and try to subtract.
   assign trial = {rem_ff, num_ff[hbpf_pkg::NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The numerator register fills with quotient bits from the bottom.
         num_in = {num_ff[hbpf_pkg::NUM_W-2:0], fits};
         rem_in = fits ? diff[hbpf_pkg::DEN_W-1:0] : trial[hbpf_pkg::DEN_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == hbpf_pkg::DIV_CNT_W'(hbpf_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state resets; the data path does not need to.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quot = num_ff[hbpf_pkg::QUOT_W-1:0];

endmodule

>>> sv/hbpf_shape.sv
// Maps the divider quotient to the two bridge duties.
module hbpf_shape (
   input  logic [hbpf_pkg::QUOT_W-1:0] quot,
   input  hbpf_pkg::shape_ctrl_type    ctrl,
   output logic [hbpf_pkg::DUTY_W-1:0] duty_a,
   output logic [hbpf_pkg::DUTY_W-1:0] duty_b
);

   logic [hbpf_pkg::SHAPE_W-1:0] q;
   logic [hbpf_pkg::SHAPE_W-1:0] ramp;
   logic [hbpf_pkg::SHAPE_W-1:0] clamped;
   logic [hbpf_pkg::SHAPE_W-1:0] inverse;

   assign q = {1'b0, quot};

   // Piecewise ramp over the four quarters of a full polarity cycle.
   always_comb begin
      case ({ctrl.polarity, ctrl.high_half})
         2'b11:   ramp = hbpf_pkg::DUTY_FALL - q;
         2'b10:   ramp = q + hbpf_pkg::DUTY_MID;
         2'b00:   ramp = hbpf_pkg::DUTY_MID - q;
         default: ramp = (q >= hbpf_pkg::DUTY_MID) ? (q - hbpf_pkg::DUTY_MID) : '0;
      endcase
   end

   assign clamped = (ramp >= hbpf_pkg::DUTY_MAX) ? hbpf_pkg::DUTY_MAX : ramp;
   assign inverse = hbpf_pkg::DUTY_MAX - clamped;

   // Hard mode drives one side only; smooth mode splits complementary duties.
   always_comb begin
      if (ctrl.smooth) begin
         duty_a = clamped[hbpf_pkg::DUTY_W-1:0];
         duty_b = inverse[hbpf_pkg::DUTY_W-1:0];
      end else if (ctrl.polarity) begin
         duty_a = '0;
         duty_b = quot[hbpf_pkg::DUTY_W-1:0];
      end else begin
         duty_a = quot[hbpf_pkg::DUTY_W-1:0];
         duty_b = '0;
      end
   end

endmodule

>>> sv/hbridge_polarity_flip_pwm.sv
// Top level of the H-bridge polarity-flip PWM duty generator.
//
//   channel  direction  tdata fields (low bit up)              tlast/tuser
//   req_     in         tick[0], zero fill to 8 bits            none
//   rsp_     out        duty_a[7:0], duty_b[15:8], polarity[16] none
//   csr_     in         write enable, index, 16-bit write data  n/a
//
// An item passes through these steps from its transfer to its result: the
// transfer edge updates the counter and polarity, the prep state loads the
// divider operands, the bit-serial divider runs, the divide state sees it
// finish and the hold state loads the output register. The next input is
// taken the cycle after that load.
// Reset is synchronous and clears the counter, polarity and all handshakes.
// A result waiting on rsp_tready does not block the next input transfer; the
// following result is held in the divider until the output register frees,
// and the input stays stalled until then.
module hbridge_polarity_flip_pwm (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // tick
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [23:0]                       rsp_tdata,   // duty_a, duty_b, polarity
   input  logic                              csr_we,
   input  logic [hbpf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hbpf_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PREP = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_HOLD = 2'd3;

   logic [1:0]                        state_ff, state_in;
   logic                              smooth_ff;
   logic [hbpf_pkg::PCT_W-1:0]        pct_ff;
   logic [hbpf_pkg::COUNT_W-1:0]      period_ff;
   logic [hbpf_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic                              pol_ff, pol_in;
   hbpf_pkg::shape_ctrl_type          ctrl_ff, ctrl_in;
   logic                              out_valid_ff, out_valid_in;
   logic [hbpf_pkg::DUTY_W-1:0]       out_a_ff, out_b_ff;
   logic                              out_pol_ff;

   logic                              req_xfer;
   logic                              slot_free;
   logic [hbpf_pkg::COUNT_W-1:0]      period_eff;
   logic [hbpf_pkg::COUNT_W-1:0]      half;
   logic [hbpf_pkg::PCT_W-1:0]        pct_eff;
   logic [hbpf_pkg::COUNT_W-1:0]      count_step;
   logic                              low_half;
   logic [hbpf_pkg::NUM_W-1:0]        numer;
   logic [hbpf_pkg::DEN_W-1:0]        denom;
   logic                              div_start;
   logic                              div_done;
   logic [hbpf_pkg::QUOT_W-1:0]       quot;
   logic [hbpf_pkg::DUTY_W-1:0]       duty_a, duty_b;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign slot_free  = !out_valid_ff || rsp_tready;

   // Effective period and power after the range limits.
   assign period_eff = (period_ff < hbpf_pkg::PERIOD_MIN) ? hbpf_pkg::PERIOD_MIN : period_ff;
   assign half       = period_eff >> 1;
   assign pct_eff    = (pct_ff > hbpf_pkg::PCT_FULL) ? hbpf_pkg::PCT_FULL : pct_ff;

   // Saturating millisecond counter with a flip at the period.
   always_comb begin
      count_step = count_ff;
      if (req_tdata[0] && (count_ff != hbpf_pkg::COUNT_MAX)) begin
         count_step = count_ff + 1'b1;
      end
      count_in = count_ff;
      pol_in   = pol_ff;
      if (req_xfer) begin
         if (count_step >= period_eff) begin
            count_in = '0;
            pol_in   = !pol_ff;
         end else begin
            count_in = count_step;
         end
      end
   end

   // Divider operands: the ramp position or the hard-mode percentage.
   assign low_half = (count_ff <= half);
   always_comb begin
      ctrl_in = ctrl_ff;
      if (!smooth_ff) begin
         numer = {9'd0, pct_eff, 8'd0} - {17'd0, pct_eff};
         denom = {9'd0, hbpf_pkg::PCT_FULL};
      end else if (low_half) begin
         numer = {1'b0, count_ff, 7'd0};
         denom = half;
      end else begin
         numer = {count_ff, 8'd0} - {8'd0, count_ff};
         denom = period_eff;
      end
      if (div_start) begin
         ctrl_in.smooth    = smooth_ff;
         ctrl_in.polarity  = pol_ff;
         ctrl_in.high_half = !low_half;
      end
   end

   assign div_start = (state_ff == ST_PREP);

   hbpf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (numer),
      .denom (denom),
      .done  (div_done),
      .quot  (quot)
   );

   hbpf_shape u_shape (
      .quot   (quot),
      .ctrl   (ctrl_ff),
      .duty_a (duty_a),
      .duty_b (duty_b)
   );

   // Sequencer for one item at a time.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output register valid flag.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if ((state_ff == ST_HOLD) && slot_free) begin
         out_valid_in = 1'b1;
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pol_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
         smooth_ff    <= 1'b0;
         pct_ff       <= hbpf_pkg::PCT_RESET;
         period_ff    <= hbpf_pkg::PERIOD_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pol_ff       <= pol_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            case (csr_index)
               hbpf_pkg::CSR_SMOOTH_MODE: smooth_ff <= csr_wdata[0];
               hbpf_pkg::CSR_POWER_PCT:   pct_ff    <= csr_wdata[hbpf_pkg::PCT_W-1:0];
               hbpf_pkg::CSR_FLIP_PERIOD: period_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ctrl_ff <= ctrl_in;
      if ((state_ff == ST_HOLD) && slot_free) begin
         out_a_ff   <= duty_a;
         out_b_ff   <= duty_b;
         out_pol_ff <= ctrl_ff.polarity;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_pol_ff, out_b_ff, out_a_ff};

endmodule

>>> sv/hbpf_checker.sv
// Port-level checks for the H-bridge polarity-flip PWM block, with its bind.
module hbpf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Either one side is off or the two duties are complementary.
   a_duty_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:0] == 8'd0) || (rsp_tdata[15:8] == 8'd0) ||
                     ({1'b0, rsp_tdata[7:0]} + {1'b0, rsp_tdata[15:8]} == 9'd255))
      else $error("duty pair is neither one-sided nor complementary");

   // After an input transfer the block is busy with that item.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while an item is in progress");

   // Reset leaves the block ready with no result pending.
   a_reset: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("bad state after reset");

endmodule

bind hbridge_polarity_flip_pwm hbpf_checker u_hbpf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
